>>> rtl/gtpr_pkg.sv
// shared constants, codes and font rom of the glyph text pixel renderer
package gtpr_pkg;

	// configuration register indexes
	localparam logic [2:0] CFG_CLIP_X_MIN  = 3'd0;
	localparam logic [2:0] CFG_CLIP_X_MAX  = 3'd1;
	localparam logic [2:0] CFG_CLIP_Y_MIN  = 3'd2;
	localparam logic [2:0] CFG_CLIP_Y_MAX  = 3'd3;
	localparam logic [2:0] CFG_TERM_MODE   = 3'd4;
	localparam logic [2:0] CFG_WORD_WRAP   = 3'd5;
	localparam logic [2:0] CFG_INK_COLOR   = 3'd6;

	// command codes
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_CHAR  = 1'b1;

	// character codes
	localparam logic [6:0] CHAR_LF    = 7'd10;
	localparam logic [6:0] CHAR_CR    = 7'd13;
	localparam logic [6:0] FIRST_CODE = 7'd32;

	localparam int ROM_COLS   = 6;
	localparam int ROM_GLYPHS = 96;

	// one entry per glyph, column 0 in the low byte, bit r of a byte is row r
	localparam logic [47:0] FONT_ROM [ROM_GLYPHS] = '{
		48'h000000000000, 48'h00000000005F, 48'h000000070007, 48'h00147F147F14,
		48'h00122A7F2A24, 48'h006264081323, 48'h005022554936, 48'h000000000305,
		48'h00000041221C, 48'h0000001C2241, 48'h00082A1C2A08, 48'h0008083E0808,
		48'h000000003050, 48'h000000080808, 48'h000000003030, 48'h000204081020,
		48'h003E4549513E, 48'h000000407F42, 48'h004649516142, 48'h00314B454121,
		48'h00107F121418, 48'h003945454527, 48'h003049494A3C, 48'h000305097101,
		48'h003649494936, 48'h001E29494906, 48'h000000000036, 48'h000000003656,
		48'h000041221408, 48'h000000141414, 48'h000008142241, 48'h000609510102,
		48'h003E41794932, 48'h00007E11117E, 48'h00003649497F, 48'h00002241413E,
		48'h00001C22417F, 48'h00004149497F, 48'h00000109097F, 48'h00003251413E,
		48'h00007F08087F, 48'h000000417F41, 48'h00013F414020, 48'h00412214087F,
		48'h00000040407F, 48'h007F0204027F, 48'h007F1008047F, 48'h00003E41413E,
		48'h00000609097F, 48'h005E2151413E, 48'h00004629197F, 48'h000031494946,
		48'h000000017F01, 48'h00003F40403F, 48'h001F2040201F, 48'h007F2018207F,
		48'h006314081463, 48'h000304780403, 48'h004345495161, 48'h00000041417F,
		48'h002010080402, 48'h0000007F4141, 48'h000402010204, 48'h000000404040,
		48'h000000040201, 48'h000078545420, 48'h00003844487F, 48'h000000444438,
		48'h00007F484438, 48'h000018545438, 48'h000001097E08, 48'h00003C541408,
		48'h00007804087F, 48'h000000407D44, 48'h00003D444020, 48'h00004428107F,
		48'h000000407F41, 48'h00780418047C, 48'h00007804087C, 48'h000038444438,
		48'h00000814147C, 48'h00007C181408, 48'h00000804087C, 48'h000020545448,
		48'h000040443F04, 48'h00007C20403C, 48'h001C2040201C, 48'h003C4030403C,
		48'h004428102844, 48'h00003C50500C, 48'h00444C546444, 48'h000000413608,
		48'h00000000007F, 48'h000000083641, 48'h0000081C2A08, 48'h0000082A1C08
	};

	// column byte of a glyph; control codes and columns past the rom are blank
	function automatic logic [7:0] font_col(input logic [6:0] code, input logic [2:0] c);
		logic [6:0]  idx;
		logic [47:0] shifted;
		idx = code - FIRST_CODE;
		shifted = FONT_ROM[idx] >> {c, 3'b000};
		if (code < FIRST_CODE || 32'(c) >= ROM_COLS) begin
			return 8'h00;
		end
		return shifted[7:0];
	endfunction

endpackage

>>> rtl/glyph_text_pixel_renderer_top.sv
// glyph text pixel renderer: character items in, clipped pixel write items out
// a start, cr, lf or control item goes straight to the finish state, which offers its single result;
// a printable item scans its glyph one row bit per cycle, column by column, unless the output stalls,
// then closes in the finish state and returns to idle, where the next item is accepted
// reset (arst_n low) clears cursor, origin, configuration to defaults and all valids
module glyph_text_pixel_renderer_top #(
	parameter int GLYPH_WIDTH  = 6,
	parameter int GLYPH_HEIGHT = 8,
	parameter int SCREEN_ROWS  = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [7:0]  cfg_data,
	// input items
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // char_code[6:0], start_x[22:7], start_y[38:23]
	input  logic        s_axis_tuser,  // cmd
	// result items
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // pixel_x[6:0], pixel_y[12:7], pixel_state[13]
	output logic        m_axis_tuser,  // pixel_valid
	output logic        m_axis_tlast
);

	localparam int CW = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 1;
	localparam int RW = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_DRAW   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t state_q;

	// configuration
	logic [6:0] clip_x_min_q;
	logic [7:0] clip_x_max_q;
	logic [6:0] clip_y_min_q;
	logic [6:0] clip_y_max_q;
	logic       term_mode_q;
	logic       word_wrap_q;
	logic       ink_color_q;

	// cursor state
	logic [15:0] cursor_col_q;
	logic [15:0] cursor_row_q;
	logic [15:0] origin_col_q;

	// glyph scan
	logic [6:0]    code_q;
	logic [7:0]    col_bits_q;
	logic          col_blank_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	// one found pixel held back until it is known whether it is the last
	logic       pend_valid_q;
	logic [6:0] pend_x_q;
	logic [5:0] pend_y_q;

	logic [6:0] in_code;
	logic [15:0] in_x;
	logic [15:0] in_y;
	assign in_code = s_axis_tdata[6:0];
	assign in_x    = s_axis_tdata[22:7];
	assign in_y    = s_axis_tdata[38:23];

	logic accept;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept = s_axis_tvalid && s_axis_tready;

	logic push_ok;
	assign push_ok = !m_axis_tvalid || m_axis_tready;

	logic signed [17:0] px, py;
	logic in_clip, hit, stall, row_end, col_final;
	logic [2:0] col_next;

	always_comb begin
		px = $signed({{2{cursor_col_q[15]}}, cursor_col_q}) + $signed(18'(col_q));
		py = $signed({{2{cursor_row_q[15]}}, cursor_row_q}) + $signed(18'(row_q));
		in_clip = (px >= 18'sd0) && (px <= 18'sd127)
			&& (px >= $signed({11'b0, clip_x_min_q})) && (px < $signed({10'b0, clip_x_max_q}))
			&& (py >= 18'sd0) && (py < $signed(18'(SCREEN_ROWS)))
			&& (py >= $signed({11'b0, clip_y_min_q})) && (py < $signed({11'b0, clip_y_max_q}));
		hit = col_bits_q[0] && in_clip;
		stall = hit && pend_valid_q && !push_ok;
		row_end = (row_q == RW'(GLYPH_HEIGHT - 1));
		// compact mode stops on the first blank column after column 0
		col_final = (col_q == CW'(GLYPH_WIDTH - 1))
			|| (!term_mode_q && (col_q != '0) && col_blank_q);
		col_next = 3'(col_q) + 3'd1;
	end

	// a result is loaded into the output register
	logic push;
	assign push = (state_q == ST_DRAW && !stall && hit && pend_valid_q)
		|| (state_q == ST_FINISH && push_ok);

	// cursor after the glyph, with word wrap
	logic [15:0]        adv_col;
	logic signed [17:0] wrap_test;
	logic               wrap;
	always_comb begin
		adv_col = cursor_col_q + 16'(col_q) + 16'd1;
		wrap_test = $signed({{2{adv_col[15]}}, adv_col}) + $signed(18'(GLYPH_WIDTH));
		wrap = word_wrap_q && (wrap_test > $signed({10'b0, clip_x_max_q}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_x_min_q <= 7'd0;
			clip_x_max_q <= 8'd96;
			clip_y_min_q <= 7'd0;
			clip_y_max_q <= 7'd64;
			term_mode_q  <= 1'b0;
			word_wrap_q  <= 1'b0;
			ink_color_q  <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_addr)
				gtpr_pkg::CFG_CLIP_X_MIN: clip_x_min_q <= cfg_data[6:0];
				gtpr_pkg::CFG_CLIP_X_MAX: clip_x_max_q <= cfg_data;
				gtpr_pkg::CFG_CLIP_Y_MIN: clip_y_min_q <= cfg_data[6:0];
				gtpr_pkg::CFG_CLIP_Y_MAX: clip_y_max_q <= cfg_data[6:0];
				gtpr_pkg::CFG_TERM_MODE:  term_mode_q  <= cfg_data[0];
				gtpr_pkg::CFG_WORD_WRAP:  word_wrap_q  <= cfg_data[0];
				gtpr_pkg::CFG_INK_COLOR:  ink_color_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cursor_col_q  <= '0;
			cursor_row_q  <= '0;
			origin_col_q  <= '0;
			pend_valid_q  <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (push) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					pend_valid_q <= 1'b0;
					if (accept) begin
						state_q <= ST_FINISH;
						if (s_axis_tuser == gtpr_pkg::CMD_START) begin
							cursor_col_q <= in_x;
							origin_col_q <= in_x;
							cursor_row_q <= in_y;
						end else if (in_code == gtpr_pkg::CHAR_CR) begin
							cursor_col_q <= origin_col_q;
						end else if (in_code == gtpr_pkg::CHAR_LF) begin
							cursor_row_q <= cursor_row_q + 16'(GLYPH_HEIGHT);
						end else if (in_code >= gtpr_pkg::FIRST_CODE) begin
							state_q <= ST_DRAW;
						end
					end
				end
				ST_DRAW: begin
					if (!stall) begin
						if (hit) begin
							pend_valid_q <= 1'b1;
						end
						if (row_end && col_final) begin
							state_q <= ST_FINISH;
							if (wrap) begin
								cursor_col_q <= origin_col_q;
								cursor_row_q <= cursor_row_q + 16'(GLYPH_HEIGHT);
							end else begin
								cursor_col_q <= adv_col;
							end
						end
					end
				end
				ST_FINISH: begin
					if (push_ok) begin
						pend_valid_q  <= 1'b0;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// glyph scan datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			code_q      <= in_code;
			col_bits_q  <= gtpr_pkg::font_col(in_code, 3'd0);
			col_blank_q <= (gtpr_pkg::font_col(in_code, 3'd0) == 8'h00);
			col_q       <= '0;
			row_q       <= '0;
		end else if (state_q == ST_DRAW && !stall) begin
			if (hit) begin
				pend_x_q <= px[6:0];
				pend_y_q <= py[5:0];
			end
			if (row_end) begin
				row_q <= '0;
				if (!col_final) begin
					col_q       <= col_q + CW'(1);
					col_bits_q  <= gtpr_pkg::font_col(code_q, col_next);
					col_blank_q <= (gtpr_pkg::font_col(code_q, col_next) == 8'h00);
				end
			end else begin
				row_q      <= row_q + RW'(1);
				col_bits_q <= {1'b0, col_bits_q[7:1]};
			end
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (state_q == ST_DRAW && hit && pend_valid_q && push_ok) begin
			m_axis_tdata <= {2'b00, ink_color_q, pend_y_q, pend_x_q};
			m_axis_tuser <= 1'b1;
			m_axis_tlast <= 1'b0;
		end else if (state_q == ST_FINISH && push_ok) begin
			if (pend_valid_q) begin
				m_axis_tdata <= {2'b00, ink_color_q, pend_y_q, pend_x_q};
				m_axis_tuser <= 1'b1;
			end else begin
				m_axis_tdata <= '0;
				m_axis_tuser <= 1'b0;
			end
			m_axis_tlast <= 1'b1;
		end
	end

	// nothing is held back between items
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |=> !pend_valid_q || (state_q != ST_IDLE))
		else $error("pending pixel left over while idle");

	// an empty result always closes its item
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
		else $error("empty result without last");

	// an accepted item always leaves idle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != ST_IDLE))
		else $error("accepted item did not start");

	// a stalled scan keeps its position
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAW && stall) |=> ($stable(row_q) && $stable(col_q)
			&& (state_q == ST_DRAW)))
		else $error("scan moved while stalled");

endmodule
